@@ sv/edbp_pkg.sv @@
// shared types, constants and helpers of the edid block parser
package edbp_pkg;

	localparam logic [7:0] BLOCK_LEN   = 8'd128;
	localparam logic [7:0] LAST_OFFSET = 8'd127;
	localparam logic [7:0] DESC_START  = 8'd54;
	localparam logic [7:0] DESC_END    = 8'd126;
	localparam logic [7:0] HDR_LEN     = 8'd8;
	localparam logic [7:0] OFF_VENDOR_HI = 8'd8;
	localparam logic [7:0] OFF_VENDOR_LO = 8'd9;
	localparam logic [7:0] OFF_WIDTH   = 8'd21;
	localparam logic [7:0] OFF_HEIGHT  = 8'd22;

	localparam logic [4:0] POS_TYPE      = 5'd3;
	localparam logic [4:0] POS_FLAG      = 5'd4;
	localparam logic [4:0] POS_TEXT_LAST = 5'd17;

	localparam logic [7:0] LINE_FEED   = 8'h0a;
	localparam logic [7:0] TYPE_NAME   = 8'hfc;
	localparam logic [7:0] TYPE_SERIAL = 8'hff;

	localparam logic [1:0] KIND_SUMMARY = 2'd0;
	localparam logic [1:0] KIND_NAME    = 2'd1;
	localparam logic [1:0] KIND_SERIAL  = 2'd2;

	localparam logic [1:0] ASCII_UPPER = 2'b10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] text_char;
		logic       char_valid;
		logic       text_end;
		logic       checksum_ok;
		logic       header_ok;
		logic [6:0] vendor_first;
		logic [6:0] vendor_second;
		logic [6:0] vendor_third;
		logic [7:0] horiz_size;
		logic [7:0] vert_size;
		logic       size_valid;
	} out_item_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] val;
		case (idx)
			3'd0: val = 8'h00;
			3'd7: val = 8'h00;
			default: val = 8'hff;
		endcase
		return val;
	endfunction

endpackage

@@ sv/edbp_in_if.sv @@
// input channel: one edid byte per item
interface edbp_in_if;
	logic               valid;
	logic               ready;
	edbp_pkg::in_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

@@ sv/edbp_out_if.sv @@
// output channel: text character or block summary items
interface edbp_out_if;
	logic                valid;
	logic                ready;
	edbp_pkg::out_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

@@ sv/edid_block_parser.sv @@
// edid base block parser top level
// Takes one EDID byte per item and can accept a byte every clock cycle. Each byte updates
// the offset, checksum, header flag, captured fields and descriptor tracking in one
// pass; any text character or block summary it causes is registered. Results go
// through a two-entry output buffer, so the input stalls while both entries are full.
// The summary arrives after the byte at offset 127; bytes past the block are dropped
// until a byte with restart set.
module edid_block_parser (
	input logic clk,
	input logic arst_n,
	edbp_in_if.sink    in_ch,
	edbp_out_if.source out_ch
);

	logic [7:0] off_q, cks_q, vhi_q, vlo_q, wid_q, hgt_q;
	logic       hdr_q, dclr_q, tfin_q;
	logic [4:0] dpos_q;
	logic [1:0] dkind_q;

	logic [7:0] off_e, cks_e, vhi_e, vlo_e, wid_e, hgt_e;
	logic       hdr_e, dclr_e, tfin_e;
	logic [4:0] dpos_e;
	logic [1:0] dkind_e;

	logic [7:0] off_n, cks_n, vhi_n, vlo_n, wid_n, hgt_n;
	logic       hdr_n, dclr_n, tfin_n;
	logic [4:0] dpos_n;
	logic [1:0] dkind_n;

	logic                accept;
	logic [7:0]          b;
	logic                res_valid;
	edbp_pkg::out_item_t res;

	logic                out_valid_q, skid_valid_q;
	edbp_pkg::out_item_t out_q, skid_q;
	logic                out_take;

	assign accept   = in_ch.valid && in_ch.ready;
	assign b        = in_ch.item.data_byte;
	assign out_take = out_valid_q && out_ch.ready;

	assign in_ch.ready  = !skid_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_q;

	always_comb begin
		if (in_ch.item.restart) begin
			off_e   = '0;
			cks_e   = '0;
			hdr_e   = 1'b1;
			vhi_e   = '0;
			vlo_e   = '0;
			wid_e   = '0;
			hgt_e   = '0;
			dpos_e  = '0;
			dclr_e  = 1'b1;
			dkind_e = edbp_pkg::KIND_SUMMARY;
			tfin_e  = 1'b0;
		end else begin
			off_e   = off_q;
			cks_e   = cks_q;
			hdr_e   = hdr_q;
			vhi_e   = vhi_q;
			vlo_e   = vlo_q;
			wid_e   = wid_q;
			hgt_e   = hgt_q;
			dpos_e  = dpos_q;
			dclr_e  = dclr_q;
			dkind_e = dkind_q;
			tfin_e  = tfin_q;
		end
	end

	always_comb begin
		off_n     = off_e;
		cks_n     = cks_e;
		hdr_n     = hdr_e;
		vhi_n     = vhi_e;
		vlo_n     = vlo_e;
		wid_n     = wid_e;
		hgt_n     = hgt_e;
		dpos_n    = dpos_e;
		dclr_n    = dclr_e;
		dkind_n   = dkind_e;
		tfin_n    = tfin_e;
		res_valid = 1'b0;
		res       = '0;
		if (off_e < edbp_pkg::BLOCK_LEN) begin
			cks_n = cks_e + b;
			if (off_e < edbp_pkg::HDR_LEN && b != edbp_pkg::hdr_byte(off_e[2:0])) begin
				hdr_n = 1'b0;
			end
			if (off_e == edbp_pkg::OFF_VENDOR_HI) vhi_n = b;
			if (off_e == edbp_pkg::OFF_VENDOR_LO) vlo_n = b;
			if (off_e == edbp_pkg::OFF_WIDTH) wid_n = b;
			if (off_e == edbp_pkg::OFF_HEIGHT) hgt_n = b;

			if (off_e >= edbp_pkg::DESC_START && off_e < edbp_pkg::DESC_END) begin
				if (dpos_e < edbp_pkg::POS_TYPE || dpos_e == edbp_pkg::POS_FLAG) begin
					if (b != 8'h00) dclr_n = 1'b0;
					if (dpos_e == edbp_pkg::POS_FLAG) tfin_n = 1'b0;
				end else if (dpos_e == edbp_pkg::POS_TYPE) begin
					if (b == edbp_pkg::TYPE_NAME) dkind_n = edbp_pkg::KIND_NAME;
					else if (b == edbp_pkg::TYPE_SERIAL) dkind_n = edbp_pkg::KIND_SERIAL;
					else dkind_n = edbp_pkg::KIND_SUMMARY;
				end else if (dclr_e && dkind_e != edbp_pkg::KIND_SUMMARY && !tfin_e) begin
					res_valid = 1'b1;
					res.kind  = dkind_e;
					if (b == edbp_pkg::LINE_FEED) begin
						res.text_end = 1'b1;
						tfin_n       = 1'b1;
					end else begin
						res.text_char  = b;
						res.char_valid = 1'b1;
						if (dpos_e == edbp_pkg::POS_TEXT_LAST) begin
							res.text_end = 1'b1;
							tfin_n       = 1'b1;
						end
					end
				end
				if (dpos_e == edbp_pkg::POS_TEXT_LAST) begin
					dpos_n  = '0;
					dclr_n  = 1'b1;
					dkind_n = edbp_pkg::KIND_SUMMARY;
					tfin_n  = 1'b0;
				end else begin
					dpos_n = dpos_e + 5'd1;
				end
			end

			if (off_e == edbp_pkg::LAST_OFFSET) begin
				res_valid         = 1'b1;
				res               = '0;
				res.kind          = edbp_pkg::KIND_SUMMARY;
				res.checksum_ok   = (cks_n == 8'h00);
				res.header_ok     = hdr_n;
				res.vendor_first  = {edbp_pkg::ASCII_UPPER, vhi_n[6:2]};
				res.vendor_second = {edbp_pkg::ASCII_UPPER, vhi_n[1:0], vlo_n[7:5]};
				res.vendor_third  = {edbp_pkg::ASCII_UPPER, vlo_n[4:0]};
				res.horiz_size    = wid_n;
				res.vert_size     = hgt_n;
				res.size_valid    = (wid_n != 8'h00) && (hgt_n != 8'h00);
			end
			off_n = off_e + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			cks_q   <= '0;
			hdr_q   <= 1'b1;
			vhi_q   <= '0;
			vlo_q   <= '0;
			wid_q   <= '0;
			hgt_q   <= '0;
			dpos_q  <= '0;
			dclr_q  <= 1'b1;
			dkind_q <= edbp_pkg::KIND_SUMMARY;
			tfin_q  <= 1'b0;
		end else if (accept) begin
			off_q   <= off_n;
			cks_q   <= cks_n;
			hdr_q   <= hdr_n;
			vhi_q   <= vhi_n;
			vlo_q   <= vlo_n;
			wid_q   <= wid_n;
			hgt_q   <= hgt_n;
			dpos_q  <= dpos_n;
			dclr_q  <= dclr_n;
			dkind_q <= dkind_n;
			tfin_q  <= tfin_n;
		end
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept && res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output empty");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= edbp_pkg::BLOCK_LEN)
		else $error("byte offset beyond block");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		dpos_q <= edbp_pkg::POS_TEXT_LAST)
		else $error("descriptor position out of range");

	a_summary_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == edbp_pkg::KIND_SUMMARY)
			|-> (!out_q.char_valid && !out_q.text_end))
		else $error("summary item carries text flags");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_ch.ready) |=> $stable(skid_q))
		else $error("skid entry changed while stalled");

endmodule
